// ===== rtl/core/iidl_pkg.sv =====
// Shared types and constants for the indexed insert/delete list.
package iidl_pkg;

    // Number of cells in the list and the width of one stored element.
    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 32;

    // Field widths of the request and result words.
    localparam int POS_W    = 4;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STATUS_W = 2;
    localparam int REQ_W    = 2;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_INSERT = 2'd2,
        ST_BAD_DELETE = 2'd3
    } t_status;

    // What one cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

endpackage

// ===== rtl/core/indexed_insert_delete_list.sv =====
// Top level of the indexed insert/delete list: request decode, cell row and result register.
//
// The list keeps up to CAPACITY element words in a row of cells plus a count. Each request
// word (insert, delete or clear) yields exactly one result word in the next cycle, and while
// o_in_stall is low a new request is taken every cycle: cells from the position up move one
// place at once, each loading the new word or a neighbor. The result register decouples the
// two sides, so requests keep flowing while the output is not stalled; while a result is held
// by i_out_stall, o_in_stall is raised. Entries above the count are never output.
module indexed_insert_delete_list
    import iidl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [POS_W-1:0]         i_position,
    input  logic [ELEMENT_WIDTH-1:0] i_element_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ELEMENT_WIDTH-1:0] o_removed_element,
    output logic [CNT_W-1:0]         o_count_out,
    output logic                     o_empty_flag
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [ELEMENT_WIDTH-1:0] r_removed;
    logic [ELEMENT_WIDTH-1:0] n_removed;

    logic                     accept;
    logic                     ins_ok;
    logic                     del_ok;
    logic [CNT_W-1:0]         pos_ext;
    t_req_type                req;
    logic [ELEMENT_WIDTH-1:0] words [CAPACITY];

    assign req        = t_req_type'(i_req_type);
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign pos_ext    = CNT_W'(i_position);

    // Decode the request against the current count.
    always_comb begin
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
        n_status  = ST_DONE;
        n_count   = r_count;
        n_removed = '0;
        case (req)
            REQ_INSERT: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else if (pos_ext > r_count) begin
                    n_status = ST_BAD_INSERT;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (pos_ext >= r_count) begin
                    n_status = ST_BAD_DELETE;
                end else begin
                    del_ok    = 1'b1;
                    n_removed = words[i_position];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Per-cell shift control and the row of cells.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [ELEMENT_WIDTH-1:0] left_word;
            logic [ELEMENT_WIDTH-1:0] right_word;
            t_cell_op                 cell_op;

            always_comb begin
                cell_op = CELL_HOLD;
                if (accept && ins_ok) begin
                    if (CNT_W'(gi) == pos_ext) begin
                        cell_op = CELL_LOAD_NEW;
                    end else if (CNT_W'(gi) > pos_ext) begin
                        cell_op = CELL_FROM_LEFT;
                    end
                end else if (accept && del_ok) begin
                    if (CNT_W'(gi) >= pos_ext) begin
                        cell_op = CELL_FROM_RIGHT;
                    end
                end
            end

            if (gi == 0) begin : g_first
                assign left_word = i_element_in;
            end else begin : g_inner_left
                assign left_word = words[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_word = words[gi];
            end else begin : g_inner_right
                assign right_word = words[gi+1];
            end

            iidl_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (cell_op),
                .i_new_word   (i_element_in),
                .i_left_word  (left_word),
                .i_right_word (right_word),
                .o_word       (words[gi])
            );
        end
    endgenerate

    // Output valid follows accepted requests and drains when the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_removed_element = r_removed;
    assign o_count_out       = r_count;
    assign o_empty_flag      = (r_count == '0);

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // An accepted clear leaves the list empty.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req == REQ_CLEAR) |=> (r_count == '0 && o_empty_flag))
        else $error("clear did not empty the list");

    // A successful insert grows the count by one and reports done.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ins_ok) |=> (r_count == $past(r_count) + CNT_W'(1) && r_status == ST_DONE))
        else $error("insert did not grow the list by one");

    // A refused delete leaves the count and reports nothing removed.
    a_bad_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req == REQ_DELETE && !del_ok) |=>
            (r_count == $past(r_count) && r_removed == '0))
        else $error("refused delete changed the list");

endmodule

// ===== rtl/core/iidl_cell.sv =====
// One storage cell of the list: holds one element and trades it with its neighbors.
module iidl_cell
    import iidl_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_op                 i_op,
    input  logic [ELEMENT_WIDTH-1:0] i_new_word,
    input  logic [ELEMENT_WIDTH-1:0] i_left_word,
    input  logic [ELEMENT_WIDTH-1:0] i_right_word,
    output logic [ELEMENT_WIDTH-1:0] o_word
);

    logic [ELEMENT_WIDTH-1:0] r_word;
    logic [ELEMENT_WIDTH-1:0] n_word;

    // Select the next content of the cell.
    always_comb begin
        case (i_op)
            CELL_HOLD:       n_word = r_word;
            CELL_LOAD_NEW:   n_word = i_new_word;
            CELL_FROM_LEFT:  n_word = i_left_word;
            CELL_FROM_RIGHT: n_word = i_right_word;
            default:         n_word = r_word;
        endcase
    end

    // The element word itself needs no reset.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
